### sv/usbcts_pkg.sv
// Package for the endpoint-zero control transfer stager.
// Word types, transfer context, event/command/phase/error codes.
// No dependencies.
package usbcts_pkg;

	localparam int MaxRes = 3;              // most result words one event yields
	localparam int CntW   = 2;              // holds 0..MaxRes
	localparam logic [6:0] MaxPacketRst = 7'd64;

	// event codes
	localparam logic [2:0] ACT_BUS_RESET  = 3'd0;
	localparam logic [2:0] ACT_SETUP      = 3'd1;
	localparam logic [2:0] ACT_OUT        = 3'd2;
	localparam logic [2:0] ACT_IN_DONE    = 3'd3;
	localparam logic [2:0] ACT_STREAM_TX  = 3'd4;
	localparam logic [2:0] ACT_STREAM_ARM = 3'd5;

	// command codes
	localparam logic [2:0] CMD_TX     = 3'd0;
	localparam logic [2:0] CMD_ARM    = 3'd1;
	localparam logic [2:0] CMD_STALL  = 3'd2;
	localparam logic [2:0] CMD_SABORT = 3'd3;
	localparam logic [2:0] CMD_HDONE  = 3'd4;
	localparam logic [2:0] CMD_SREADY = 3'd5;
	localparam logic [2:0] CMD_SDATA  = 3'd6;
	localparam logic [2:0] CMD_SDONE  = 3'd7;

	// phases
	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_TXDATA   = 3'd1;
	localparam logic [2:0] PH_TXMORE   = 3'd2;
	localparam logic [2:0] PH_RXDATA   = 3'd3;
	localparam logic [2:0] PH_TXSTATUS = 3'd4;
	localparam logic [2:0] PH_RXSTATUS = 3'd5;
	localparam logic [2:0] PH_WAIT     = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_SETUP_LEN  = 3'd1;
	localparam logic [2:0] ERR_UNRESOLVED = 3'd2;
	localparam logic [2:0] ERR_REJECTED   = 3'd3;
	localparam logic [2:0] ERR_VALIDATION = 3'd4;
	localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
	localparam logic [2:0] ERR_HANDLER    = 3'd6;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] pkt_length;
		logic        setup_dir_in;
		logic [15:0] setup_wlength;
		logic        handler_found;
		logic        handler_accepted;
		logic        handler_dir_in;
		logic [15:0] handler_max_length;
		logic        use_streamer;
		logic [6:0]  reply_length;
		logic        handler_error;
	} in_word_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] cmd_length;
		logic        success;
		logic [2:0]  error_code;
		logic [2:0]  phase_now;
		logic        last;
	} out_word_t;

	// transfer context carried between events
	typedef struct packed {
		logic [2:0]  phase;
		logic [15:0] data_count;
		logic [15:0] saved_length;
		logic        streaming;
		logic        handler_active;
	} ctx_t;

endpackage

### sv/usb_control_transfer_stager_top.sv
// Top level of the USB endpoint-zero control transfer stager.
// Depends on usbcts_pkg and usbcts_step.
//
//  channel | signals                     | word type   | direction
//  --------+-----------------------------+-------------+----------
//  events  | in_valid, in_stall, in_word | in_word_t   | in
//  results | out_valid, out_stall,       | out_word_t  | out
//          | out_word                    |             |
//  config  | cfg_we, cfg_wdata           | max_packet  | in
//
// An event is taken into an input register, decoded from there, and its 0..3
// result words are loaded into a small shift list once it is free; the list
// drives the output port one word per cycle while out_stall is low. An event
// with results holds the list until its 1 to 3 words have left; silent events
// retire one per cycle. The list reload (last word leaving) sets the pace.
// arst_n clears the context, max_packet (to 64) and all valid state.
// A stalled output holds the list, which in turn stalls the event input once
// the input register is full.
module usb_control_transfer_stager_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [6:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  usbcts_pkg::in_word_t  in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output usbcts_pkg::out_word_t out_word
);

	logic [6:0]                                     max_packet_q;
	usbcts_pkg::ctx_t                               ctx_q;
	usbcts_pkg::ctx_t                               ctx_nx;
	logic                                           item_vld_s1;
	usbcts_pkg::in_word_t                           item_s1;
	usbcts_pkg::out_word_t [usbcts_pkg::MaxRes-1:0] res_q;
	logic [usbcts_pkg::CntW-1:0]                    cnt_q;
	usbcts_pkg::out_word_t [usbcts_pkg::MaxRes-1:0] step_res;
	logic [usbcts_pkg::CntW-1:0]                    step_cnt;
	logic                                           take;
	logic                                           list_free;
	logic                                           adv;
	logic                                           accept;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packet_q <= usbcts_pkg::MaxPacketRst;
		end else if (cfg_we) begin
			max_packet_q <= cfg_wdata;
		end
	end

	// handshake
	assign take      = out_valid && !out_stall;
	assign list_free = (cnt_q == '0) || (take && cnt_q == usbcts_pkg::CntW'(1));
	assign adv       = item_vld_s1 && list_free;
	assign in_stall  = item_vld_s1 && !list_free;
	assign accept    = in_valid && !in_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (accept) begin
			item_vld_s1 <= 1'b1;
		end else if (adv) begin
			item_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_word;
		end
	end

	usbcts_step u_step (
		.ctx        (ctx_q),
		.item       (item_s1),
		.max_packet (max_packet_q),
		.ctx_nx     (ctx_nx),
		.results    (step_res),
		.count      (step_cnt)
	);

	// context commits when the event's words enter the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
		end else if (adv) begin
			ctx_q <= ctx_nx;
		end
	end

	// result list, head word drives the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv) begin
			cnt_q <= step_cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= step_res;
		end else if (take) begin
			for (int k = 0; k < usbcts_pkg::MaxRes - 1; k++) begin
				res_q[k] <= res_q[k+1];
			end
		end
	end

	assign out_valid = (cnt_q != '0);
	assign out_word  = res_q[0];

	// the head word is flagged last exactly when it is the only one left
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.last == (cnt_q == usbcts_pkg::CntW'(1))))
		else $error("last flag does not match list fill");

	// a taken word that is not last leaves another word behind
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !out_word.last) |=> out_valid)
		else $error("result words lost after a non-final word");

	// context only moves when an event is retired
	a_ctx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctx_q))
		else $error("context changed without a retired event");

	// an event with no result leaves the list empty
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step_cnt == '0) |=> !out_valid)
		else $error("silent event produced output");

endmodule

### sv/usbcts_step.sv
// Event decoder for the control transfer stager: one event plus the current
// context gives the next context and up to MaxRes result words.
// Depends on usbcts_pkg.
module usbcts_step (
	input  usbcts_pkg::ctx_t                              ctx,
	input  usbcts_pkg::in_word_t                          item,
	input  logic [6:0]                                    max_packet,
	output usbcts_pkg::ctx_t                              ctx_nx,
	output usbcts_pkg::out_word_t [usbcts_pkg::MaxRes-1:0] results,
	output logic [usbcts_pkg::CntW-1:0]                   count
);

	// one bit wider than the count, for the last-word compare
	localparam int CntW = usbcts_pkg::CntW + 1;

	function automatic usbcts_pkg::out_word_t mk(
		input logic [2:0]  cmd,
		input logic [15:0] len,
		input logic        ok,
		input logic [2:0]  err
	);
		usbcts_pkg::out_word_t w;
		w.command    = cmd;
		w.cmd_length = len;
		w.success    = ok;
		w.error_code = err;
		w.phase_now  = usbcts_pkg::PH_IDLE;
		w.last       = 1'b0;
		return w;
	endfunction

	usbcts_pkg::ctx_t                               nx;
	usbcts_pkg::out_word_t [usbcts_pkg::MaxRes-1:0] res;
	logic [usbcts_pkg::CntW-1:0]                    n;
	logic [2:0]                                     err;
	logic [15:0]                                    mp16;
	logic [15:0]                                    len;
	logic [15:0]                                    room;
	logic [16:0]                                    sum;
	logic                                           ok_dir;

	always_comb begin
		nx     = ctx;
		res    = '0;
		n      = '0;
		err    = usbcts_pkg::ERR_NONE;
		mp16   = {9'd0, max_packet};
		len    = '0;
		room   = '0;
		sum    = '0;
		ok_dir = 1'b0;

		unique case (item.action)
			usbcts_pkg::ACT_BUS_RESET: begin
				nx.phase = usbcts_pkg::PH_IDLE;
				if (nx.streaming) begin
					res[n] = mk(usbcts_pkg::CMD_SABORT, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
					nx.streaming = 1'b0;
				end
				res[n] = mk(usbcts_pkg::CMD_ARM, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
				n = n + 1'b1;
			end
			usbcts_pkg::ACT_SETUP: begin
				// drop whoever owned the previous transfer
				if (nx.streaming) begin
					res[n] = mk(usbcts_pkg::CMD_SABORT, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
					nx.streaming = 1'b0;
				end else if (nx.handler_active) begin
					res[n] = mk(usbcts_pkg::CMD_HDONE, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
				end
				nx.handler_active = 1'b0;
				nx.phase          = usbcts_pkg::PH_IDLE;
				nx.data_count     = '0;

				if (item.pkt_length != 16'd8) begin
					err = usbcts_pkg::ERR_SETUP_LEN;
				end else begin
					nx.saved_length = item.setup_wlength;
					if (!item.handler_found) begin
						err = usbcts_pkg::ERR_UNRESOLVED;
					end else begin
						nx.handler_active = 1'b1;
						if (!item.handler_accepted) begin
							err = usbcts_pkg::ERR_REJECTED;
						end else begin
							nx.streaming = item.use_streamer;
							ok_dir = (item.handler_dir_in == item.setup_dir_in) &&
								(item.setup_wlength <= item.handler_max_length);
							if (ok_dir && !nx.streaming)
								ok_dir = item.setup_wlength <= mp16;
							if (!ok_dir) begin
								err = usbcts_pkg::ERR_VALIDATION;
							end else if (item.setup_dir_in) begin
								if (nx.streaming) begin
									nx.phase = usbcts_pkg::PH_WAIT;
									res[n] = mk(usbcts_pkg::CMD_SREADY, 16'd0, 1'b0,
										usbcts_pkg::ERR_NONE);
									n = n + 1'b1;
								end else if (item.handler_error) begin
									err = usbcts_pkg::ERR_HANDLER;
								end else begin
									len = {9'd0, item.reply_length};
									if (len > item.setup_wlength) len = item.setup_wlength;
									if (len > mp16) len = mp16;
									res[n] = mk(usbcts_pkg::CMD_TX, len, 1'b0,
										usbcts_pkg::ERR_NONE);
									n = n + 1'b1;
									nx.phase = usbcts_pkg::PH_TXDATA;
								end
							end else if (item.setup_wlength == 16'd0) begin
								if (nx.streaming) begin
									// zero-length streamed OUT: done at once
									res[n] = mk(usbcts_pkg::CMD_SDATA, 16'd0, 1'b0,
										usbcts_pkg::ERR_NONE);
									n = n + 1'b1;
									nx.phase = usbcts_pkg::PH_TXSTATUS;
									res[n] = mk(usbcts_pkg::CMD_TX, 16'd0, 1'b0,
										usbcts_pkg::ERR_NONE);
									n = n + 1'b1;
								end else if (item.handler_error) begin
									err = usbcts_pkg::ERR_HANDLER;
								end else begin
									nx.phase = usbcts_pkg::PH_TXSTATUS;
									res[n] = mk(usbcts_pkg::CMD_TX, 16'd0, 1'b0,
										usbcts_pkg::ERR_NONE);
									n = n + 1'b1;
								end
							end else begin
								nx.phase = usbcts_pkg::PH_RXDATA;
								res[n] = mk(usbcts_pkg::CMD_ARM, 16'd0, 1'b0,
									usbcts_pkg::ERR_NONE);
								n = n + 1'b1;
							end
						end
					end
				end
			end
			usbcts_pkg::ACT_OUT: begin
				if (ctx.phase == usbcts_pkg::PH_RXSTATUS) begin
					if (nx.streaming) begin
						res[n] = mk(usbcts_pkg::CMD_SDONE, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
						n = n + 1'b1;
						nx.streaming = 1'b0;
					end else if (nx.handler_active) begin
						res[n] = mk(usbcts_pkg::CMD_HDONE, 16'd0, 1'b1, usbcts_pkg::ERR_NONE);
						n = n + 1'b1;
					end
					nx.handler_active = 1'b0;
					nx.phase = usbcts_pkg::PH_IDLE;
					res[n] = mk(usbcts_pkg::CMD_ARM, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
				end else if (ctx.phase == usbcts_pkg::PH_RXDATA) begin
					if (ctx.streaming) begin
						sum = {1'b0, ctx.data_count} + {1'b0, item.pkt_length};
						if (sum > {1'b0, ctx.saved_length}) begin
							err = usbcts_pkg::ERR_TOO_LONG;
						end else begin
							nx.phase = usbcts_pkg::PH_WAIT;
							nx.data_count = sum[15:0];
							res[n] = mk(usbcts_pkg::CMD_SDATA, item.pkt_length, 1'b0,
								usbcts_pkg::ERR_NONE);
							n = n + 1'b1;
							if (sum[15:0] >= ctx.saved_length) begin
								nx.phase = usbcts_pkg::PH_TXSTATUS;
								res[n] = mk(usbcts_pkg::CMD_TX, 16'd0, 1'b0,
									usbcts_pkg::ERR_NONE);
								n = n + 1'b1;
							end
						end
					end else if (item.handler_error) begin
						err = usbcts_pkg::ERR_HANDLER;
					end else begin
						nx.phase = usbcts_pkg::PH_TXSTATUS;
						res[n] = mk(usbcts_pkg::CMD_TX, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
						n = n + 1'b1;
					end
				end
			end
			usbcts_pkg::ACT_IN_DONE: begin
				if (ctx.phase == usbcts_pkg::PH_TXSTATUS) begin
					if (nx.streaming) begin
						res[n] = mk(usbcts_pkg::CMD_SDONE, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
						n = n + 1'b1;
						nx.streaming = 1'b0;
					end else if (nx.handler_active) begin
						res[n] = mk(usbcts_pkg::CMD_HDONE, 16'd0, 1'b1, usbcts_pkg::ERR_NONE);
						n = n + 1'b1;
					end
					nx.handler_active = 1'b0;
					nx.phase = usbcts_pkg::PH_IDLE;
					res[n] = mk(usbcts_pkg::CMD_ARM, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
				end else if (ctx.phase == usbcts_pkg::PH_TXDATA) begin
					nx.phase = usbcts_pkg::PH_RXSTATUS;
					res[n] = mk(usbcts_pkg::CMD_ARM, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
				end else if (ctx.phase == usbcts_pkg::PH_TXMORE) begin
					nx.phase = usbcts_pkg::PH_WAIT;
					res[n] = mk(usbcts_pkg::CMD_SREADY, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
				end
			end
			usbcts_pkg::ACT_STREAM_TX: begin
				if (ctx.streaming && ctx.phase == usbcts_pkg::PH_WAIT) begin
					room = (ctx.saved_length >= ctx.data_count) ?
						ctx.saved_length - ctx.data_count : 16'd0;
					len = item.pkt_length;
					if (len > room) len = room;
					if (len > mp16) len = mp16;
					res[n] = mk(usbcts_pkg::CMD_TX, len, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
					nx.data_count = ctx.data_count + len;
					if (nx.data_count == ctx.saved_length || len < mp16)
						nx.phase = usbcts_pkg::PH_TXDATA;
					else
						nx.phase = usbcts_pkg::PH_TXMORE;
				end
			end
			usbcts_pkg::ACT_STREAM_ARM: begin
				if (ctx.streaming && ctx.phase == usbcts_pkg::PH_WAIT) begin
					res[n] = mk(usbcts_pkg::CMD_ARM, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
					n = n + 1'b1;
					nx.phase = usbcts_pkg::PH_RXDATA;
				end
			end
			default: begin
			end
		endcase

		// failure: stall both, then release the owner; OUT stays unarmed
		if (err != usbcts_pkg::ERR_NONE) begin
			nx.phase = usbcts_pkg::PH_IDLE;
			res[n] = mk(usbcts_pkg::CMD_STALL, 16'd0, 1'b0, err);
			n = n + 1'b1;
			if (nx.streaming) begin
				res[n] = mk(usbcts_pkg::CMD_SABORT, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
				n = n + 1'b1;
				nx.streaming = 1'b0;
			end else if (nx.handler_active) begin
				res[n] = mk(usbcts_pkg::CMD_HDONE, 16'd0, 1'b0, usbcts_pkg::ERR_NONE);
				n = n + 1'b1;
			end
			nx.handler_active = 1'b0;
		end

		for (int k = 0; k < usbcts_pkg::MaxRes; k++) begin
			res[k].phase_now = nx.phase;
			res[k].last      = ({1'b0, n} == CntW'(k + 1)) ? 1'b1 : 1'b0;
		end
	end

	assign ctx_nx  = nx;
	assign results = res;
	assign count   = n;

endmodule

### verif/usb_control_transfer_stager_top_tb.sv
// Testbench for usb_control_transfer_stager_top: directed and random control transfers.
// A scoreboard class predicts every result word and checks each one against the block's output.
// Depends on usbcts_pkg and the stager RTL.
module usb_control_transfer_stager_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Predicts the command words of the endpoint-zero stager and checks the output stream
	// against them. It keeps its own copy of the transfer context and of max_packet.
	class stager_scoreboard;
		logic [6:0]            max_packet;
		logic [2:0]            phase;
		logic [15:0]           data_count;
		logic [15:0]           saved_length;
		bit                    streaming;
		bit                    handler_active;
		usbcts_pkg::out_word_t cmds_due[$];
		usbcts_pkg::out_word_t step_cmds[$];
		int                    errors;

		function new();
			max_packet     = usbcts_pkg::MaxPacketRst;
			phase          = usbcts_pkg::PH_IDLE;
			data_count     = '0;
			saved_length   = '0;
			streaming      = 1'b0;
			handler_active = 1'b0;
			errors         = 0;
		endfunction

		function void put(logic [2:0] cmd, logic [15:0] len, logic ok, logic [2:0] err);
			usbcts_pkg::out_word_t w;
			w = '0;
			w.command    = cmd;
			w.cmd_length = len;
			w.success    = ok;
			w.error_code = err;
			step_cmds.push_back(w);
		endfunction

		// whoever owns the transfer is told it is over without success
		function void release_owner();
			if (streaming) begin
				put(usbcts_pkg::CMD_SABORT, '0, 1'b0, usbcts_pkg::ERR_NONE);
				streaming = 1'b0;
			end else if (handler_active) begin
				put(usbcts_pkg::CMD_HDONE, '0, 1'b0, usbcts_pkg::ERR_NONE);
			end
			handler_active = 1'b0;
		endfunction

		function void abort_transfer(logic [2:0] err);
			phase = usbcts_pkg::PH_IDLE;
			put(usbcts_pkg::CMD_STALL, '0, 1'b0, err);
			release_owner();
		endfunction

		function void close_transfer();
			if (streaming) begin
				put(usbcts_pkg::CMD_SDONE, '0, 1'b0, usbcts_pkg::ERR_NONE);
				streaming = 1'b0;
			end else if (handler_active) begin
				put(usbcts_pkg::CMD_HDONE, '0, 1'b1, usbcts_pkg::ERR_NONE);
			end
			handler_active = 1'b0;
			phase = usbcts_pkg::PH_IDLE;
			put(usbcts_pkg::CMD_ARM, '0, 1'b0, usbcts_pkg::ERR_NONE);
		endfunction

		function void take_stream_data(logic [15:0] len);
			phase = usbcts_pkg::PH_WAIT;
			data_count = data_count + len;
			put(usbcts_pkg::CMD_SDATA, len, 1'b0, usbcts_pkg::ERR_NONE);
			if (data_count >= saved_length) begin
				phase = usbcts_pkg::PH_TXSTATUS;
				put(usbcts_pkg::CMD_TX, '0, 1'b0, usbcts_pkg::ERR_NONE);
			end
		endfunction

		function void on_setup(usbcts_pkg::in_word_t w);
			bit          ok;
			logic [15:0] len;
			release_owner();
			phase = usbcts_pkg::PH_IDLE;
			data_count = '0;
			if (w.pkt_length != 16'd8) begin
				abort_transfer(usbcts_pkg::ERR_SETUP_LEN);
				return;
			end
			saved_length = w.setup_wlength;
			if (!w.handler_found) begin
				abort_transfer(usbcts_pkg::ERR_UNRESOLVED);
				return;
			end
			handler_active = 1'b1;
			if (!w.handler_accepted) begin
				abort_transfer(usbcts_pkg::ERR_REJECTED);
				return;
			end
			streaming = w.use_streamer;
			ok = (w.handler_dir_in == w.setup_dir_in) &&
				(w.setup_wlength <= w.handler_max_length);
			if (ok && !streaming)
				ok = w.setup_wlength <= {9'd0, max_packet};
			if (!ok) begin
				abort_transfer(usbcts_pkg::ERR_VALIDATION);
				return;
			end
			if (w.setup_dir_in) begin
				if (streaming) begin
					phase = usbcts_pkg::PH_WAIT;
					put(usbcts_pkg::CMD_SREADY, '0, 1'b0, usbcts_pkg::ERR_NONE);
				end else begin
					if (w.handler_error) begin
						abort_transfer(usbcts_pkg::ERR_HANDLER);
						return;
					end
					len = {9'd0, w.reply_length};
					if (len > w.setup_wlength)
						len = w.setup_wlength;
					if (len > {9'd0, max_packet})
						len = {9'd0, max_packet};
					put(usbcts_pkg::CMD_TX, len, 1'b0, usbcts_pkg::ERR_NONE);
					phase = usbcts_pkg::PH_TXDATA;
				end
			end else if (w.setup_wlength == 16'd0) begin
				if (streaming) begin
					take_stream_data('0);
				end else if (w.handler_error) begin
					abort_transfer(usbcts_pkg::ERR_HANDLER);
				end else begin
					phase = usbcts_pkg::PH_TXSTATUS;
					put(usbcts_pkg::CMD_TX, '0, 1'b0, usbcts_pkg::ERR_NONE);
				end
			end else begin
				phase = usbcts_pkg::PH_RXDATA;
				put(usbcts_pkg::CMD_ARM, '0, 1'b0, usbcts_pkg::ERR_NONE);
			end
		endfunction

		function void on_out(usbcts_pkg::in_word_t w);
			if (phase == usbcts_pkg::PH_RXSTATUS) begin
				close_transfer();
			end else if (phase == usbcts_pkg::PH_RXDATA) begin
				if (streaming) begin
					if ({1'b0, data_count} + {1'b0, w.pkt_length} > {1'b0, saved_length})
						abort_transfer(usbcts_pkg::ERR_TOO_LONG);
					else
						take_stream_data(w.pkt_length);
				end else if (w.handler_error) begin
					abort_transfer(usbcts_pkg::ERR_HANDLER);
				end else begin
					phase = usbcts_pkg::PH_TXSTATUS;
					put(usbcts_pkg::CMD_TX, '0, 1'b0, usbcts_pkg::ERR_NONE);
				end
			end
		endfunction

		function void on_in_done();
			if (phase == usbcts_pkg::PH_TXSTATUS) begin
				close_transfer();
			end else if (phase == usbcts_pkg::PH_TXDATA) begin
				phase = usbcts_pkg::PH_RXSTATUS;
				put(usbcts_pkg::CMD_ARM, '0, 1'b0, usbcts_pkg::ERR_NONE);
			end else if (phase == usbcts_pkg::PH_TXMORE) begin
				phase = usbcts_pkg::PH_WAIT;
				put(usbcts_pkg::CMD_SREADY, '0, 1'b0, usbcts_pkg::ERR_NONE);
			end
		endfunction

		function void on_stream_send(usbcts_pkg::in_word_t w);
			logic [15:0] room;
			logic [15:0] len;
			if (!streaming || phase != usbcts_pkg::PH_WAIT)
				return;
			room = (saved_length >= data_count) ? saved_length - data_count : 16'd0;
			len = w.pkt_length;
			if (len > room)
				len = room;
			if (len > {9'd0, max_packet})
				len = {9'd0, max_packet};
			put(usbcts_pkg::CMD_TX, len, 1'b0, usbcts_pkg::ERR_NONE);
			data_count = data_count + len;
			if (data_count == saved_length || len < {9'd0, max_packet})
				phase = usbcts_pkg::PH_TXDATA;
			else
				phase = usbcts_pkg::PH_TXMORE;
		endfunction

		// one accepted event word: work out its command words and queue them
		function void note_event(usbcts_pkg::in_word_t w);
			usbcts_pkg::out_word_t c;
			step_cmds.delete();
			case (w.action)
				usbcts_pkg::ACT_BUS_RESET: begin
					phase = usbcts_pkg::PH_IDLE;
					if (streaming) begin
						put(usbcts_pkg::CMD_SABORT, '0, 1'b0, usbcts_pkg::ERR_NONE);
						streaming = 1'b0;
					end
					put(usbcts_pkg::CMD_ARM, '0, 1'b0, usbcts_pkg::ERR_NONE);
				end
				usbcts_pkg::ACT_SETUP:     on_setup(w);
				usbcts_pkg::ACT_OUT:       on_out(w);
				usbcts_pkg::ACT_IN_DONE:   on_in_done();
				usbcts_pkg::ACT_STREAM_TX: on_stream_send(w);
				usbcts_pkg::ACT_STREAM_ARM: begin
					if (streaming && phase == usbcts_pkg::PH_WAIT) begin
						put(usbcts_pkg::CMD_ARM, '0, 1'b0, usbcts_pkg::ERR_NONE);
						phase = usbcts_pkg::PH_RXDATA;
					end
				end
				default: ;
			endcase
			foreach (step_cmds[k]) begin
				c = step_cmds[k];
				c.phase_now = phase;
				c.last = (k == step_cmds.size() - 1);
				cmds_due.push_back(c);
			end
		endfunction

		// fields shown as cmd/len/ok/err/phase/last
		function void check_cmd(usbcts_pkg::out_word_t got);
			usbcts_pkg::out_word_t want;
			if (cmds_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got %0d/%0d/%0d/%0d/%0d/%0d",
					$time, got.command, got.cmd_length, got.success, got.error_code,
					got.phase_now, got.last);
				return;
			end
			want = cmds_due.pop_front();
			if (got.command !== want.command || got.cmd_length !== want.cmd_length ||
			    got.success !== want.success || got.error_code !== want.error_code ||
			    got.phase_now !== want.phase_now || got.last !== want.last) begin
				errors++;
				$display(
					"%0t: mismatch, expected %0d/%0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d/%0d",
					$time, want.command, want.cmd_length, want.success, want.error_code,
					want.phase_now, want.last, got.command, got.cmd_length, got.success,
					got.error_code, got.phase_now, got.last);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [6:0]            cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	usbcts_pkg::in_word_t  in_word;
	logic                  out_valid;
	logic                  out_stall;
	usbcts_pkg::out_word_t out_word;

	stager_scoreboard sb;

	// idle odds per cycle, in percent, for the event sender and the result receiver
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int events_sent = 0;
	// a request for one long receiver hold-off; the receiver counts it down itself
	bit hold_req = 1'b0;
	int hold_left = 0;

	usb_control_transfer_stager_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always #10 clk = ~clk;

	// Result side: random stall, or a long hold-off when asked. A word leaves the block
	// at an edge where out_valid is high and out_stall is low; values seen here are the
	// ones from before the edge, since everything is updated with nonblocking assignments.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_cmd(out_word);
	end

	// Offer one event word, idling first at random, and hold it until taken.
	// The sender notes the word itself so that the next choice sees the updated context.
	task automatic send_event(input usbcts_pkg::in_word_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		sb.note_event(w);
		events_sent++;
	endtask

	// Stop offering, wait for every predicted word, then give the block time to
	// retire events that produce nothing.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.cmds_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_max_packet(input logic [6:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.max_packet = v;
	endtask

	// fully random content, reply length kept to its legal range
	function automatic usbcts_pkg::in_word_t noise_word();
		usbcts_pkg::in_word_t w;
		w = {$urandom, $urandom};
		w.reply_length = 7'($urandom_range(0, 64));
		return w;
	endfunction

	function automatic usbcts_pkg::in_word_t event_word(input logic [2:0] act,
			input logic [15:0] len);
		usbcts_pkg::in_word_t w;
		w = noise_word();
		w.action = act;
		w.pkt_length = len;
		w.handler_error = ($urandom_range(19) == 0);
		return w;
	endfunction

	// a well-formed setup word: resolved, accepted, direction and length agree
	function automatic usbcts_pkg::in_word_t setup_word(input bit dir_in, input bit stream,
			input logic [15:0] wlen);
		usbcts_pkg::in_word_t w;
		int                   top;
		w = noise_word();
		top = int'(wlen) + $urandom_range(0, 300);
		w.action = usbcts_pkg::ACT_SETUP;
		w.pkt_length = 16'd8;
		w.setup_dir_in = dir_in;
		w.setup_wlength = wlen;
		w.handler_found = 1'b1;
		w.handler_accepted = 1'b1;
		w.handler_dir_in = dir_in;
		w.handler_max_length = (top > 65535) ? 16'hFFFF : 16'(top);
		w.use_streamer = stream;
		w.handler_error = ($urandom_range(15) == 0);
		return w;
	endfunction

	// One random control transfer: a setup, mostly sound but sometimes broken, then the
	// events each phase waits for, with a little noise mixed in.
	task automatic run_transfer();
		usbcts_pkg::in_word_t w;
		bit                   dir_in;
		bit                   stream;
		int                   mp;
		int                   wlen;
		int                   room;
		int                   len;
		int                   steps;
		mp = sb.max_packet;
		dir_in = 1'($urandom_range(1));
		stream = 1'($urandom_range(1));
		if (!stream)
			wlen = $urandom_range(0, mp);
		else if ($urandom_range(9) == 0)
			wlen = $urandom_range(0, 65535);
		else
			wlen = $urandom_range(0, 4 * mp);
		w = setup_word(dir_in, stream, 16'(wlen));
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(4))
				0: w.pkt_length = $urandom_range(1) ? 16'($urandom_range(0, 7))
					: 16'($urandom_range(9, 65535));
				1: w.handler_found = 1'b0;
				2: w.handler_accepted = 1'b0;
				3: w.handler_dir_in = ~w.handler_dir_in;
				default: begin
					if (wlen != 0)
						w.handler_max_length = 16'(wlen - 1);
					else
						w.setup_wlength = 16'(mp + 1);
				end
			endcase
		end
		send_event(w);
		for (steps = 0; steps < 40 && sb.phase != usbcts_pkg::PH_IDLE; steps++) begin
			if ($urandom_range(99) < 6) begin
				send_event(noise_word());
			end else begin
				case (sb.phase)
					usbcts_pkg::PH_TXDATA, usbcts_pkg::PH_TXMORE, usbcts_pkg::PH_TXSTATUS:
						send_event(event_word(usbcts_pkg::ACT_IN_DONE, 16'($urandom)));
					usbcts_pkg::PH_RXSTATUS:
						send_event(event_word(usbcts_pkg::ACT_OUT, '0));
					usbcts_pkg::PH_RXDATA: begin
						room = int'(sb.saved_length) - int'(sb.data_count);
						if (room < 0)
							room = 0;
						if (!sb.streaming)
							len = $urandom_range(0, 65535);
						else if ($urandom_range(9) == 0)
							len = room + 1 + $urandom_range(0, 20);
						else
							len = $urandom_range(0, (room < mp) ? room : mp);
						if (len > 65535)
							len = 65535;
						send_event(event_word(usbcts_pkg::ACT_OUT, 16'(len)));
					end
					usbcts_pkg::PH_WAIT: begin
						if (!dir_in) begin
							send_event(event_word(usbcts_pkg::ACT_STREAM_ARM, 16'($urandom)));
						end else begin
							case ($urandom_range(2))
								0: len = mp;
								1: len = $urandom_range(0, 2 * mp);
								default: len = $urandom_range(0, 65535);
							endcase
							send_event(event_word(usbcts_pkg::ACT_STREAM_TX, 16'(len)));
						end
					end
					default: send_event(noise_word());
				endcase
			end
		end
	endtask

	initial begin
		usbcts_pkg::in_word_t w;
		sb = new();
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = usbcts_pkg::MaxPacketRst;
		in_valid  = 1'b0;
		in_word   = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with max_packet still at its reset value.
		// Bus reset from idle just re-arms OUT; unused actions and out-of-phase events
		// must produce nothing.
		send_event(event_word(usbcts_pkg::ACT_BUS_RESET, '0));
		w = noise_word(); w.action = 3'd6; send_event(w);
		w = noise_word(); w.action = 3'd7; send_event(w);
		send_event(event_word(usbcts_pkg::ACT_OUT, 16'd8));
		send_event(event_word(usbcts_pkg::ACT_IN_DONE, '0));
		send_event(event_word(usbcts_pkg::ACT_STREAM_TX, 16'hFFFF));
		send_event(event_word(usbcts_pkg::ACT_STREAM_ARM, '0));

		// setup failures: bad length at both ends, unresolved, rejected, validation
		w = setup_word(1'b1, 1'b0, 16'd8); w.pkt_length = 16'd0; send_event(w);
		w = setup_word(1'b0, 1'b0, 16'd8); w.pkt_length = 16'hFFFF; send_event(w);
		w = setup_word(1'b1, 1'b0, 16'd4); w.handler_found = 1'b0; send_event(w);
		w = setup_word(1'b1, 1'b0, 16'd4); w.handler_accepted = 1'b0; send_event(w);
		w = setup_word(1'b1, 1'b0, 16'd4); w.handler_dir_in = 1'b0; send_event(w);

		// one-shot IN with the reply clamped to wLength, then status and completion
		w = setup_word(1'b1, 1'b0, 16'd10);
		w.reply_length = 7'd64; w.handler_error = 1'b0;
		send_event(w);
		send_event(event_word(usbcts_pkg::ACT_IN_DONE, '0));
		send_event(event_word(usbcts_pkg::ACT_OUT, '0));

		// handler failure on a one-shot IN, and a one-shot longer than max_packet
		w = setup_word(1'b1, 1'b0, 16'd64); w.handler_error = 1'b1; send_event(w);
		w = setup_word(1'b1, 1'b0, 16'd65); send_event(w);

		// zero-length OUT goes straight to status
		w = setup_word(1'b0, 1'b0, 16'd0); w.handler_error = 1'b0; send_event(w);
		send_event(event_word(usbcts_pkg::ACT_IN_DONE, '0));

		// streamed IN of the largest size, a full send clamped to max_packet, then a bus
		// reset that aborts the streamer; the handler is only told at the next setup
		w = setup_word(1'b1, 1'b1, 16'hFFFF); w.handler_max_length = 16'hFFFF; send_event(w);
		send_event(event_word(usbcts_pkg::ACT_STREAM_TX, 16'hFFFF));
		send_event(event_word(usbcts_pkg::ACT_BUS_RESET, '0));
		w = setup_word(1'b0, 1'b1, 16'd5); send_event(w);
		send_event(event_word(usbcts_pkg::ACT_OUT, 16'd6));

		// streamed OUT of zero length completes through the streamer
		w = setup_word(1'b0, 1'b1, 16'd0); send_event(w);
		send_event(event_word(usbcts_pkg::ACT_IN_DONE, '0));

		// Random part in three rounds, each at its own max_packet. Sender slow and
		// receiver slower, then the reverse, then both flat out with one long hold-off
		// on the result side so the block backs up into its event input.
		set_max_packet(7'd8);
		tx_idle_pct = 29;
		rx_idle_pct = 69;
		while (events_sent < 130)
			run_transfer();

		set_max_packet(7'd37);
		tx_idle_pct = 69;
		rx_idle_pct = 29;
		while (events_sent < 230)
			run_transfer();

		set_max_packet(7'd64);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 1'b1;
		while (events_sent < 330)
			run_transfer();

		settle();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// hard stop in case the block hangs
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
sv/usbcts_pkg.sv
sv/usbcts_step.sv
sv/usb_control_transfer_stager_top.sv
verif/usb_control_transfer_stager_top_tb.sv
